FILE: hw/rtl/mcc_pkg.sv
// Package for the column consensus block: field widths, base codes and the
// request/response structs of the shared divider. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mcc_pkg;

  localparam int unsigned ColW      = 10;
  localparam int unsigned CodeW     = 3;
  localparam int unsigned WeightW   = 16;
  localparam int unsigned BaseW     = 2;
  localparam int unsigned SupportW  = 17;
  localparam int unsigned CountW    = 9;
  localparam int unsigned WsumW     = 24;
  localparam int unsigned TotalW    = WsumW + 2;
  localparam int unsigned RemW      = TotalW + 1;
  localparam int unsigned RangeW    = 11;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned NumBases  = 4;
  localparam int unsigned DivSteps  = SupportW;
  localparam int unsigned DivCntW   = $clog2(DivSteps);

  localparam logic [CodeW-1:0] BaseA = 3'd0;
  localparam logic [CodeW-1:0] BaseC = 3'd1;
  localparam logic [CodeW-1:0] BaseG = 3'd2;
  localparam logic [CodeW-1:0] BaseT = 3'd3;
  localparam logic [CodeW-1:0] BaseZ = 3'd4;

  localparam logic [CfgIdxW-1:0] RegSubjectBegin = 1'd0;
  localparam logic [CfgIdxW-1:0] RegSubjectEnd   = 1'd1;

  localparam logic [WsumW-1:0]  WsumMax = {WsumW{1'b1}};
  localparam logic [CountW-1:0] CntMax  = {CountW{1'b1}};

  typedef struct packed {
    logic              start;
    logic [WsumW-1:0]  win;
    logic [TotalW-1:0] total;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [SupportW-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mcc_if.sv
// Handshake channels of the consensus block: cell input, result output and
// register writes. Depends on mcc_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface mcc_in_if;
  import mcc_pkg::*;
  logic               valid;
  logic               ready;
  logic [ColW-1:0]    column;
  logic [CodeW-1:0]   base_code;
  logic [WeightW-1:0] cell_weight;
  logic [CodeW-1:0]   subject_base;
  logic               last_row;
  modport source (output valid, column, base_code, cell_weight, subject_base, last_row,
                  input ready);
  modport sink (input valid, column, base_code, cell_weight, subject_base, last_row,
                output ready);
endinterface

interface mcc_out_if;
  import mcc_pkg::*;
  logic                valid;
  logic                ready;
  logic [ColW-1:0]     out_column;
  logic [BaseW-1:0]    consensus_base;
  logic [SupportW-1:0] support;
  logic [CountW-1:0]   coverage;
  logic                orig_valid;
  logic [WsumW-1:0]    orig_weight;
  logic [CountW-1:0]   orig_count;
  modport source (output valid, out_column, consensus_base, support, coverage, orig_valid,
                  orig_weight, orig_count, input ready);
  modport sink (input valid, out_column, consensus_base, support, coverage, orig_valid,
                orig_weight, orig_count, output ready);
endinterface

interface mcc_cfg_if;
  import mcc_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [RangeW-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/msa_column_weighted_consensus.sv
// Weighted majority-vote consensus of one alignment column, one cell per beat.
// A row beat without last_row is accumulated; a last_row beat presents its result after
// 4 scan steps, 1 divider start, 17 divider steps, 1 quotient capture and 1 output load,
// paced by the bit-serial divider. Throughput: 1 row per cycle while input ready is high;
// input ready drops after each last_row beat until its result is loaded into the output register.
// Reset: asynchronous active low; clears accumulators, span registers, sequencer and the output beat.
`timescale 1ns / 1ps
`default_nettype none

module msa_column_weighted_consensus (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  mcc_in_if.sink    in_i,
  mcc_out_if.source out_o,
  mcc_cfg_if.sink   cfg_i
);
  import mcc_pkg::*;

  // sequencer codes
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StScan  = 3'd1;
  localparam logic [2:0] StStart = 3'd2;
  localparam logic [2:0] StDiv   = 3'd3;
  localparam logic [2:0] StHold  = 3'd4;

  logic [2:0] state_q, state_d;

  // configuration registers; writes always land
  logic [RangeW-1:0] subj_begin_q, subj_end_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      subj_begin_q <= '0;
      subj_end_q   <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        RegSubjectBegin: subj_begin_q <= cfg_i.data;
        RegSubjectEnd:   subj_end_q   <= cfg_i.data;
        default:         ;
      endcase
    end
  end

  // per-column accumulators
  logic [WsumW-1:0]  wsum_q [NumBases];
  logic [CountW-1:0] cnt_q  [NumBases];
  logic [CountW-1:0] cover_q;

  logic in_fire, is_base, acc_clear;
  logic [BaseW-1:0]   acc_sel;
  logic [WsumW:0]     wsum_add;
  logic [WsumW-1:0]   wsum_sat;

  assign in_i.ready = (state_q == StIdle);
  assign in_fire    = in_i.valid && in_i.ready;
  assign is_base    = in_i.base_code < BaseZ;
  assign acc_sel    = in_i.base_code[BaseW-1:0];
  assign wsum_add   = {1'b0, wsum_q[acc_sel]} + (WsumW+1)'(in_i.cell_weight);
  assign wsum_sat   = wsum_add[WsumW] ? WsumMax : wsum_add[WsumW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < NumBases; b++) begin
        wsum_q[b] <= '0;
        cnt_q[b]  <= '0;
      end
      cover_q <= '0;
    end else if (acc_clear) begin
      for (int b = 0; b < NumBases; b++) begin
        wsum_q[b] <= '0;
        cnt_q[b]  <= '0;
      end
      cover_q <= '0;
    end else if (in_fire && is_base) begin
      // add weight and counts, saturate at full scale
      wsum_q[acc_sel] <= wsum_sat;
      if (cnt_q[acc_sel] != CntMax) cnt_q[acc_sel] <= cnt_q[acc_sel] + 1'b1;
      if (cover_q != CntMax) cover_q <= cover_q + 1'b1;
    end
  end

  // column context captured from the last row
  logic [ColW-1:0]  col_q;
  logic [BaseW-1:0] sbase_q;
  logic             ovalid_q;
  logic             in_range;

  assign in_range = (subj_begin_q <= {1'b0, in_i.column})
                 && ({1'b0, in_i.column} < subj_end_q);

  always_ff @(posedge clk_i) begin
    if (in_fire && in_i.last_row) begin
      col_q    <= in_i.column;
      sbase_q  <= in_i.subject_base[BaseW-1:0];
      ovalid_q <= (in_i.subject_base < BaseZ) && in_range;
    end
  end

  // scan: one base per cycle through a shared compare and adder
  logic [BaseW-1:0]  idx_q, idx_d;
  logic [WsumW-1:0]  win_q, win_d;
  logic [BaseW-1:0]  cons_q, cons_d;
  logic [TotalW-1:0] total_q, total_d;
  logic [SupportW-1:0] sup_q, sup_d;

  div_req_t div_req;
  div_rsp_t div_rsp;

  mcc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign div_req.start = (state_q == StStart);
  assign div_req.win   = win_q;
  assign div_req.total = total_q;

  // output beat register
  logic out_valid_q;
  logic out_free;

  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    win_d     = win_q;
    cons_d    = cons_q;
    total_d   = total_q;
    sup_d     = sup_q;
    acc_clear = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_fire && in_i.last_row) begin
          state_d = StScan;
          idx_d   = '0;
          win_d   = '0;
          cons_d  = '0;
          total_d = '0;
        end
      end
      StScan: begin
        // strict compare keeps the earlier base on a tie
        if (wsum_q[idx_q] > win_q) begin
          win_d  = wsum_q[idx_q];
          cons_d = idx_q;
        end
        total_d = total_q + TotalW'(wsum_q[idx_q]);
        idx_d   = idx_q + 1'b1;
        if (idx_q == BaseW'(NumBases - 1)) state_d = StStart;
      end
      StStart: begin
        state_d = StDiv;
      end
      StDiv: begin
        if (div_rsp.done) begin
          sup_d   = (total_q == '0) ? '0 : div_rsp.quotient;
          state_d = StHold;
        end
      end
      StHold: begin
        if (out_free) begin
          acc_clear = 1'b1;
          state_d   = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q   <= win_d;
    cons_q  <= cons_d;
    total_q <= total_d;
    sup_q   <= sup_d;
  end

  // load the result beat; hold it until the sink takes it
  logic                load_out;
  logic [ColW-1:0]     o_col_q;
  logic [BaseW-1:0]    o_cons_q;
  logic [SupportW-1:0] o_sup_q;
  logic [CountW-1:0]   o_cover_q;
  logic                o_ovalid_q;
  logic [WsumW-1:0]    o_oweight_q;
  logic [CountW-1:0]   o_ocount_q;

  assign load_out = (state_q == StHold) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      o_col_q     <= col_q;
      o_cons_q    <= cons_q;
      o_sup_q     <= sup_q;
      o_cover_q   <= cover_q;
      o_ovalid_q  <= ovalid_q;
      o_oweight_q <= ovalid_q ? wsum_q[sbase_q] : '0;
      o_ocount_q  <= ovalid_q ? cnt_q[sbase_q] : '0;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.out_column     = o_col_q;
  assign out_o.consensus_base = o_cons_q;
  assign out_o.support        = o_sup_q;
  assign out_o.coverage       = o_cover_q;
  assign out_o.orig_valid     = o_ovalid_q;
  assign out_o.orig_weight    = o_oweight_q;
  assign out_o.orig_count     = o_ocount_q;

endmodule

`default_nettype wire

FILE: hw/rtl/mcc_div.sv
// Bit-serial restoring divider: floor(win * 2^16 / total), one quotient bit
// per cycle, win <= total assumed. Depends on mcc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mcc_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire mcc_pkg::div_req_t req_i,
  output mcc_pkg::div_rsp_t      rsp_o
);
  import mcc_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [DivCntW-1:0]  cnt_q, cnt_d;
  logic [RemW-1:0]     rem_q, rem_d;
  logic [TotalW-1:0]   dvs_q, dvs_d;
  logic [SupportW-1:0] quo_q, quo_d;
  logic                fits;
  logic [RemW-1:0]     rem_sub;

  assign fits    = rem_q >= {1'b0, dvs_q};
  assign rem_sub = fits ? (rem_q - {1'b0, dvs_q}) : rem_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = RemW'(req_i.win);
      dvs_d  = req_i.total;
      quo_d  = '0;
    end else if (busy_q) begin
      // remainder stays below the divisor, so the shift cannot drop a bit
      rem_d = {rem_sub[RemW-2:0], 1'b0};
      quo_d = {quo_q[SupportW-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// Self-checking testbench for msa_column_weighted_consensus: drives column cells,
// predicts each column's consensus result and compares it beat by beat.
// Depends on mcc_pkg, the mcc_*_if interfaces and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
  import mcc_pkg::*;

  // Hang detection: cycles with no beat on any channel before giving up.
  localparam int unsigned StallLimit   = 3000;
  // Quiet time after the last result before a register write or the end.
  localparam int unsigned SettleCycles = 32;
  localparam int unsigned NumSpans     = 7;

  typedef struct packed {
    logic [ColW-1:0]    column;
    logic [CodeW-1:0]   base_code;
    logic [WeightW-1:0] cell_weight;
    logic [CodeW-1:0]   subject_base;
    logic               last_row;
  } cell_t;

  typedef struct packed {
    logic [ColW-1:0]     out_column;
    logic [BaseW-1:0]    consensus_base;
    logic [SupportW-1:0] support;
    logic [CountW-1:0]   coverage;
    logic                orig_valid;
    logic [WsumW-1:0]    orig_weight;
    logic [CountW-1:0]   orig_count;
  } consensus_t;

  logic clk_i;
  logic rst_ni;

  mcc_in_if  cell_ch ();
  mcc_out_if cons_ch ();
  mcc_cfg_if reg_ch ();

  msa_column_weighted_consensus i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cell_ch),
    .out_o  (cons_ch),
    .cfg_i  (reg_ch)
  );

  // Cells waiting for the driver and the results they are expected to produce.
  cell_t      pending_cells[$];
  consensus_t expected_consensus[$];
  cell_t      cell_on_bus;

  // Shadow of the block: subject span registers and per-column accumulators.
  logic [RangeW-1:0] subj_begin_q = '0;
  logic [RangeW-1:0] subj_end_q   = '0;
  logic [WsumW-1:0]  base_wsum[NumBases];
  logic [CountW-1:0] base_rows[NumBases];
  logic [CountW-1:0] covered_rows;

  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  bit          idle_en = 1'b1;

  int unsigned span_begin[NumSpans] = '{0, 100, 1024, 0, 1024, 1023, 500};
  int unsigned span_end[NumSpans]   = '{1024, 200, 1024, 0, 0, 1024, 501};

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Fold one accepted cell into the shadow accumulators; on the last row of a
  // column, queue the expected result and clear for the next column.
  task automatic tally_cell(input cell_t c);
    consensus_t        r;
    logic [WsumW:0]    s;
    logic [1:0]        b;
    longint unsigned   win;
    longint unsigned   total;
    logic [BaseW-1:0]  lead;
    bit                in_span;
    if (c.base_code < NumBases) begin
      b = c.base_code[1:0];
      s = base_wsum[b] + c.cell_weight;
      // Saturate rather than wrap on very deep columns.
      base_wsum[b] = (s > WsumMax) ? WsumMax : s[WsumW-1:0];
      if (base_rows[b] != CntMax) base_rows[b] = base_rows[b] + 1'b1;
      if (covered_rows != CntMax) covered_rows = covered_rows + 1'b1;
    end
    // Gaps and the unused codes above gap add nothing.
    if (!c.last_row) return;

    // Strict compare keeps the earlier base on a tie.
    lead = '0;
    win  = base_wsum[0];
    for (int i = 1; i < NumBases; i++) begin
      if (base_wsum[i] > win) begin
        win  = base_wsum[i];
        lead = i[BaseW-1:0];
      end
    end
    total = base_wsum[0];
    for (int i = 1; i < NumBases; i++) total += base_wsum[i];

    in_span = (c.subject_base < NumBases) && (c.column >= subj_begin_q)
              && (c.column < subj_end_q);

    r.out_column     = c.column;
    r.consensus_base = lead;
    r.support        = (total == 0) ? '0 : SupportW'((win << 16) / total);
    r.coverage       = covered_rows;
    r.orig_valid     = in_span;
    r.orig_weight    = in_span ? base_wsum[c.subject_base[1:0]] : '0;
    r.orig_count     = in_span ? base_rows[c.subject_base[1:0]] : '0;
    expected_consensus.push_back(r);

    for (int i = 0; i < NumBases; i++) begin
      base_wsum[i] = '0;
      base_rows[i] = '0;
    end
    covered_rows = '0;
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Cell driver: hold a beat until it is taken, then present the next one
  // unless a random gap falls on this cycle.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      cell_ch.valid <= 1'b0;
    end else begin
      if (cell_ch.valid && cell_ch.ready) tally_cell(cell_on_bus);
      if (!cell_ch.valid || cell_ch.ready) begin
        if (pending_cells.size() != 0 && !(idle_en && $urandom_range(99) < 17)) begin
          cell_on_bus = pending_cells.pop_front();
          cell_ch.valid        <= 1'b1;
          cell_ch.column       <= cell_on_bus.column;
          cell_ch.base_code    <= cell_on_bus.base_code;
          cell_ch.cell_weight  <= cell_on_bus.cell_weight;
          cell_ch.subject_base <= cell_on_bus.subject_base;
          cell_ch.last_row     <= cell_on_bus.last_row;
        end else begin
          cell_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare every accepted beat against the oldest expectation,
  // and stall the output at random.
  always @(posedge clk_i) begin
    consensus_t want;
    if (!rst_ni) begin
      cons_ch.ready <= 1'b0;
    end else begin
      if (cons_ch.valid && cons_ch.ready) begin
        if (expected_consensus.size() == 0) begin
          $display("%0t: unexpected result beat for column %0d", $time,
                   cons_ch.out_column);
          mismatches++;
        end else begin
          want = expected_consensus.pop_front();
          check_field("out_column", want.out_column, cons_ch.out_column);
          check_field("consensus_base", want.consensus_base, cons_ch.consensus_base);
          check_field("support", want.support, cons_ch.support);
          check_field("coverage", want.coverage, cons_ch.coverage);
          check_field("orig_valid", want.orig_valid, cons_ch.orig_valid);
          check_field("orig_weight", want.orig_weight, cons_ch.orig_weight);
          check_field("orig_count", want.orig_count, cons_ch.orig_count);
        end
      end
      cons_ch.ready <= !(idle_en && $urandom_range(99) < 17);
    end
  end

  // Watchdog: a run that stops moving beats on every channel is a hang.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((cell_ch.valid && cell_ch.ready) || (cons_ch.valid && cons_ch.ready)
          || (reg_ch.valid && reg_ch.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit) begin
          $display("Some tests failed");
          $finish;
        end
      end
    end
  end

  // Write one span register and mirror it in the shadow once the beat is taken.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned val);
    @(posedge clk_i);
    reg_ch.valid <= 1'b1;
    reg_ch.index <= idx;
    reg_ch.data  <= val[RangeW-1:0];
    do @(posedge clk_i); while (!reg_ch.ready);
    reg_ch.valid <= 1'b0;
    if (idx == RegSubjectBegin) subj_begin_q = val[RangeW-1:0];
    else subj_end_q = val[RangeW-1:0];
  endtask

  // Hold further stimulus until every result is back and the block is quiet.
  task automatic drain_and_settle();
    while (pending_cells.size() != 0 || cell_ch.valid || expected_consensus.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic push_cell(input int unsigned col, input logic [CodeW-1:0] code,
                           input int unsigned weight, input logic [CodeW-1:0] sbase,
                           input bit last);
    cell_t c;
    c.column       = col[ColW-1:0];
    c.base_code    = code;
    c.cell_weight  = weight[WeightW-1:0];
    c.subject_base = sbase;
    c.last_row     = last;
    pending_cells.push_back(c);
  endtask

  // Queue one column of random rows ending in last_row. A heavy column piles
  // full-scale weights mostly onto A so sums and counts saturate. A few rows
  // get a stray column or subject base to keep the block honest about which
  // row the result fields come from.
  task automatic queue_column(input int unsigned rows, input bit heavy);
    cell_t        c;
    logic [ColW-1:0]  col;
    logic [CodeW-1:0] sbase;
    int unsigned  style;
    int unsigned  pick;
    case ($urandom_range(3))
      0: col = ColW'(subj_begin_q + $urandom_range(2) - 1);
      1: col = ColW'(subj_end_q + $urandom_range(2) - 1);
      default: col = ColW'($urandom);
    endcase
    sbase = ($urandom_range(9) == 0) ? CodeW'($urandom_range(7, 4))
                                     : CodeW'($urandom_range(3));
    style = $urandom_range(3);
    for (int unsigned i = 0; i < rows; i++) begin
      c.column       = col;
      c.subject_base = sbase;
      if ($urandom_range(19) == 0) begin
        c.column       = ColW'($urandom);
        c.subject_base = CodeW'($urandom);
      end
      if (heavy) begin
        c.base_code   = ($urandom_range(15) == 0) ? CodeW'($urandom_range(4)) : BaseA;
        c.cell_weight = '1;
      end else begin
        pick = $urandom_range(19);
        if (pick < 3) c.base_code = BaseZ;
        else if (pick == 3) c.base_code = CodeW'($urandom_range(7, 5));
        else c.base_code = CodeW'($urandom_range(3));
        case (style)
          0: c.cell_weight = WeightW'($urandom);
          1: c.cell_weight = WeightW'($urandom_range(32768));
          // Coarse weights make ties between bases common.
          2: c.cell_weight = WeightW'($urandom_range(4) * 8192);
          default: begin
            pick = $urandom_range(3);
            c.cell_weight = (pick == 0) ? 16'd0 : (pick == 1) ? 16'd1
                          : (pick == 2) ? 16'd32768 : 16'hFFFF;
          end
        endcase
      end
      c.last_row = (i == rows - 1);
      pending_cells.push_back(c);
    end
  endtask

  initial begin
    int unsigned queued;
    int unsigned budget;
    int unsigned rows;

    rst_ni               = 1'b0;
    cell_ch.valid        = 1'b0;
    cell_ch.column       = '0;
    cell_ch.base_code    = '0;
    cell_ch.cell_weight  = '0;
    cell_ch.subject_base = '0;
    cell_ch.last_row     = 1'b0;
    cons_ch.ready        = 1'b0;
    reg_ch.valid         = 1'b0;
    reg_ch.index         = '0;
    reg_ch.data          = '0;
    for (int i = 0; i < NumBases; i++) begin
      base_wsum[i] = '0;
      base_rows[i] = '0;
    end
    covered_rows = '0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed columns with the subject covering the whole alignment.
    write_reg(RegSubjectBegin, 0);
    write_reg(RegSubjectEnd, 1024);
    // Single row of weight 32768 at the lowest column: support of exactly 1.0.
    push_cell(0, BaseA, 32768, BaseA, 1'b1);
    // Tie between C and G at the top column; T adds zero weight; a gap and an
    // unused code carry weight that must be ignored.
    push_cell(1023, BaseC, 65535, BaseT, 1'b0);
    push_cell(1023, BaseG, 65535, BaseT, 1'b0);
    push_cell(1023, BaseT, 0, BaseT, 1'b0);
    push_cell(1023, BaseZ, 65535, BaseT, 1'b0);
    push_cell(1023, 3'd7, 65535, BaseT, 1'b1);
    // Gaps only: zero total, no coverage, subject base "other".
    push_cell(7, BaseZ, 65535, BaseZ, 1'b0);
    push_cell(7, 3'd5, 40000, BaseZ, 1'b0);
    push_cell(7, 3'd6, 1, BaseZ, 1'b1);
    // Covered rows with zero weight: zero total, coverage 2.
    push_cell(8, BaseA, 0, BaseA, 1'b0);
    push_cell(8, BaseT, 0, BaseA, 1'b1);
    // Out-of-set subject base drops the subject fields.
    push_cell(512, BaseG, 1000, 3'd7, 1'b1);
    push_cell(513, BaseC, 2000, 3'd5, 1'b1);
    // Four-way tie keeps A.
    push_cell(341, BaseA, 12345, BaseG, 1'b0);
    push_cell(341, BaseC, 12345, BaseG, 1'b0);
    push_cell(341, BaseG, 12345, BaseG, 1'b0);
    push_cell(341, BaseT, 12345, BaseG, 1'b1);
    // T wins; subject's base C is absent from the column.
    push_cell(682, BaseA, 1, BaseC, 1'b0);
    push_cell(682, BaseT, 2, BaseC, 1'b1);
    // Result column and subject base come from the last row.
    push_cell(100, BaseC, 3, BaseZ, 1'b0);
    push_cell(200, BaseC, 5, BaseC, 1'b1);
    drain_and_settle();

    // Random phases, each under its own subject span. The first carries a
    // deep saturating column; one phase runs with no idling on either side.
    for (int unsigned p = 0; p < NumSpans; p++) begin
      write_reg(RegSubjectBegin, span_begin[p]);
      write_reg(RegSubjectEnd, span_end[p]);
      idle_en = (p != 3);
      queued  = 0;
      budget  = 190;
      if (p == 0) begin
        queue_column(600, 1'b1);
        queued = 600;
        budget = 800;
      end
      while (queued < budget) begin
        rows = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(8, 1);
        queue_column(rows, 1'b0);
        queued += rows;
      end
      drain_and_settle();
    end

    if (mismatches == 0 && expected_consensus.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: msa_column_weighted_consensus.f
hw/rtl/mcc_pkg.sv
hw/rtl/mcc_if.sv
hw/rtl/mcc_div.sv
hw/rtl/msa_column_weighted_consensus.sv
verif/tb_top.sv
